// ===== hw/rtl/tpad_pkg.sv =====
// Shared types and constants for the triac phase-angle dimmer.
// Holds request/result structs, command codes, register indexes and mapping constants.
// No dependencies.
package tpad_pkg;

    localparam int TICK_W      = 16;
    localparam int POWER_SCALE = 100;

    // Reciprocal of the power scale, rounded up, for an exact truncating divide
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(POWER_SCALE) - 64'd1) / 64'(POWER_SCALE));
    localparam int SPAN_W      = 16 + RECIP_W;

    // Gap timer stops at the smaller of its own maximum and 16 bits
    localparam logic [TICK_W-1:0] GAP_SAT =
        (TICK_W < 16) ? {TICK_W{1'b1}} : TICK_W'(17'h0FFFF);

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_ZERO_CROSS = 3'd1,
        KIND_SET_POWER  = 3'd2,
        KIND_STEP_UP    = 3'd3,
        KIND_STEP_DOWN  = 3'd4,
        KIND_SET_ON     = 3'd5,
        KIND_TOGGLE     = 3'd6
    } t_kind;

    localparam logic [2:0] CFG_POWER_STEP    = 3'd0;
    localparam logic [2:0] CFG_DELAY_AT_ZERO = 3'd1;
    localparam logic [2:0] CFG_DELAY_AT_FULL = 3'd2;
    localparam logic [2:0] CFG_GAP_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_POWER_FLOOR   = 3'd4;
    localparam logic [2:0] CFG_POWER_CEILING = 3'd5;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [7:0] power_value;
        logic              on_value;
    } t_in_item;

    typedef struct packed {
        logic        gate;
        logic        missed_zero_cross;
        logic [15:0] missed_total;
        logic [6:0]  reported_power;
        logic        is_on;
        logic [15:0] firing_delay_now;
    } t_out_item;

    typedef struct packed {
        logic [6:0]        power_step;
        logic [15:0]       delay_at_zero;
        logic [15:0]       delay_at_full;
        logic [15:0]       gap_limit;
        logic [6:0]        power_floor;
        logic [6:0]        power_ceiling;
        logic              span_neg;
        logic [SPAN_W-1:0] span_scaled;
    } t_cfg;

endpackage

// ===== hw/rtl/tpad_cfg.sv =====
// Configuration registers of the dimmer and the pre-scaled delay span.
// Depends on tpad_pkg.
module tpad_cfg
    import tpad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(16'd47000) * SPAN_W'(RECIP);

    logic [6:0]        r_power_step;
    logic [15:0]       r_delay_at_zero;
    logic [15:0]       r_delay_at_full;
    logic [15:0]       r_gap_limit;
    logic [6:0]        r_power_floor;
    logic [6:0]        r_power_ceiling;
    logic              r_span_neg;
    logic [SPAN_W-1:0] r_span_scaled;

    logic              n_span_neg;
    logic [15:0]       n_span_abs;
    logic [SPAN_W-1:0] n_span_scaled;

    always_comb begin
        n_span_neg    = r_delay_at_full < r_delay_at_zero;
        n_span_abs    = n_span_neg ? (r_delay_at_zero - r_delay_at_full)
                                   : (r_delay_at_full - r_delay_at_zero);
        n_span_scaled = SPAN_W'(n_span_abs) * SPAN_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_step    <= 7'd10;
            r_delay_at_zero <= 16'd47500;
            r_delay_at_full <= 16'd500;
            r_gap_limit     <= 16'd50025;
            r_power_floor   <= 7'd0;
            r_power_ceiling <= 7'd100;
            r_span_neg      <= 1'b1;
            r_span_scaled   <= SPAN_RESET;
        end else begin
            r_span_neg    <= n_span_neg;
            r_span_scaled <= n_span_scaled;
            if (i_wr_en) begin
                unique case (i_wr_index)
                    CFG_POWER_STEP:    r_power_step    <= i_wr_data[6:0];
                    CFG_DELAY_AT_ZERO: r_delay_at_zero <= i_wr_data;
                    CFG_DELAY_AT_FULL: r_delay_at_full <= i_wr_data;
                    CFG_GAP_LIMIT:     r_gap_limit     <= i_wr_data;
                    CFG_POWER_FLOOR:   r_power_floor   <= i_wr_data[6:0];
                    CFG_POWER_CEILING: r_power_ceiling <= i_wr_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg = '{
        power_step:    r_power_step,
        delay_at_zero: r_delay_at_zero,
        delay_at_full: r_delay_at_full,
        gap_limit:     r_gap_limit,
        power_floor:   r_power_floor,
        power_ceiling: r_power_ceiling,
        span_neg:      r_span_neg,
        span_scaled:   r_span_scaled
    };

endmodule

// ===== hw/rtl/tpad_core.sv =====
// Dimmer state and the single-pass update for one request.
// Depends on tpad_pkg; configuration comes from tpad_cfg.
module tpad_core
    import tpad_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [6:0]        r_power;
    logic              r_on;
    logic [15:0]       r_delay;
    logic [TICK_W-1:0] r_countdown;
    logic              r_armed;
    logic              r_gate;
    logic [TICK_W-1:0] r_gap;
    logic [15:0]       r_skip;

    logic [6:0]        n_power;
    logic              n_on;
    logic [15:0]       n_delay;
    logic [TICK_W-1:0] n_countdown;
    logic              n_armed;
    logic              n_gate;
    logic [TICK_W-1:0] n_gap;
    logic [15:0]       n_skip;
    logic              n_missed;

    logic signed [8:0]   clamp_in;
    logic [6:0]          clamp_out;
    logic [TICK_W-1:0]   load_val;
    logic [6:0]          map_in;
    logic [SPAN_W+6:0]   map_prod;
    logic [23:0]         map_q;
    logic signed [25:0]  map_sum;
    logic [15:0]         map_out;
    logic                delay_upd;

    // Candidate power before clamping
    always_comb begin
        case (i_item.kind)
            KIND_SET_POWER: clamp_in = {i_item.power_value[7], i_item.power_value};
            KIND_STEP_UP:   clamp_in = $signed({2'b00, r_power})
                                     + $signed({2'b00, i_cfg.power_step});
            KIND_STEP_DOWN: clamp_in = $signed({2'b00, (r_on ? r_power : 7'd0)})
                                     - $signed({2'b00, i_cfg.power_step});
            default:        clamp_in = '0;
        endcase
        // Ceiling checked first: when they cross, inputs above the ceiling get the ceiling, the rest the floor
        if (clamp_in > $signed({2'b00, i_cfg.power_ceiling})) begin
            clamp_out = i_cfg.power_ceiling;
        end else if (clamp_in < $signed({2'b00, i_cfg.power_floor})) begin
            clamp_out = i_cfg.power_floor;
        end else begin
            clamp_out = clamp_in[6:0];
        end
    end

    always_comb begin
        n_power     = r_power;
        n_on        = r_on;
        n_countdown = r_countdown;
        n_armed     = r_armed;
        n_gate      = r_gate;
        n_gap       = r_gap;
        n_skip      = r_skip;
        n_missed    = 1'b0;
        load_val    = TICK_W'(r_delay);
        if (load_val == '0) begin
            load_val = TICK_W'(1);
        end

        case (i_item.kind)
            KIND_TICK: begin
                if (r_gap < GAP_SAT) begin
                    n_gap = r_gap + TICK_W'(1);
                end
                if (r_countdown != '0) begin
                    n_countdown = r_countdown - TICK_W'(1);
                    if (n_countdown == '0 && r_on && r_armed) begin
                        n_armed = 1'b0;
                        n_gate  = 1'b1;
                    end
                end
            end
            KIND_ZERO_CROSS: begin
                n_gate = 1'b0;
                if (r_on) begin
                    n_countdown = load_val;
                    n_armed     = 1'b1;
                end
                if (32'(r_gap) >= 32'(i_cfg.gap_limit)) begin
                    n_missed = 1'b1;
                    if (r_skip != 16'hFFFF) begin
                        n_skip = r_skip + 16'd1;
                    end
                end
                n_gap = '0;
            end
            KIND_SET_POWER: n_power = clamp_out;
            KIND_STEP_UP: begin
                if (r_on) begin
                    n_power = clamp_out;
                end
            end
            KIND_STEP_DOWN: n_power = clamp_out;
            KIND_SET_ON:    n_on    = i_item.on_value;
            KIND_TOGGLE:    n_on    = !r_on;
            default: ;
        endcase
    end

    // Linear delay map: zero + sign * trunc(power * |span| / scale), saturated
    always_comb begin
        map_in   = n_on ? n_power : 7'd0;
        map_prod = (SPAN_W+7)'(map_in) * (SPAN_W+7)'(i_cfg.span_scaled);
        map_q    = map_prod[RECIP_SHIFT +: 24];
        if (i_cfg.span_neg) begin
            map_sum = $signed({10'd0, i_cfg.delay_at_zero}) - $signed({2'b00, map_q});
        end else begin
            map_sum = $signed({10'd0, i_cfg.delay_at_zero}) + $signed({2'b00, map_q});
        end
        if (map_sum < 0) begin
            map_out = '0;
        end else if (map_sum > 26'sd65535) begin
            map_out = 16'hFFFF;
        end else begin
            map_out = map_sum[15:0];
        end
        delay_upd = (n_on != r_on) || (n_on && (n_power != r_power));
        n_delay   = delay_upd ? map_out : r_delay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power     <= '0;
            r_on        <= 1'b0;
            r_delay     <= 16'd1;
            r_countdown <= '0;
            r_armed     <= 1'b0;
            r_gate      <= 1'b0;
            r_gap       <= '0;
            r_skip      <= '0;
        end else if (i_en) begin
            r_power     <= n_power;
            r_on        <= n_on;
            r_delay     <= n_delay;
            r_countdown <= n_countdown;
            r_armed     <= n_armed;
            r_gate      <= n_gate;
            r_gap       <= n_gap;
            r_skip      <= n_skip;
        end
    end

    assign o_result = '{
        gate:              n_gate,
        missed_zero_cross: n_missed,
        missed_total:      n_skip,
        reported_power:    n_on ? n_power : 7'd0,
        is_on:             n_on,
        firing_delay_now:  n_delay
    };

`ifndef SYNTHESIS
    a_gate_rises_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_gate) |-> $past(i_en && i_item.kind == KIND_TICK))
        else $error("gate rose on a request other than a tick");

    a_armed_gate_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> !r_gate)
        else $error("countdown armed while gate is already high");

    a_skip_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_skip >= $past(r_skip))
        else $error("missed-pulse count went down");

    a_gap_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.kind == KIND_ZERO_CROSS) |=> r_gap == '0)
        else $error("gap timer not cleared after zero-cross");
`endif

endmodule

// ===== hw/rtl/triac_phase_angle_dimmer.sv =====
// Triac phase-angle dimmer top level: request register, update stage, result register.
// tpad_core is the update stage; a request waits in the request register on a stall.
// Throughput: one request per cycle when not stalled, set by the single update stage.
// Reset (synchronous, active low) empties both registers and restores state and config.
// Depends on tpad_pkg, tpad_cfg and tpad_core.
module triac_phase_angle_dimmer
    import tpad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    logic      advance;
    logic      proc;
    t_cfg      cfg;
    t_out_item result;

    assign advance     = !r_out_vld || i_out_ready;
    assign proc        = r_in_vld && advance;
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    tpad_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    tpad_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
        // Payload: load on request, hold while stalled
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (proc) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
